>>> sv/sbda_pkg.sv
// ----------------------------------------------------------------------------
// sbda_pkg
// Shared types, constants and helpers for the signed binary to decimal ASCII
// converter.
// ----------------------------------------------------------------------------
`default_nettype none

package sbda_pkg;

  localparam int VALUE_W    = 64;
  localparam int CHAR_W     = 8;
  localparam int NUM_DIGITS = 20;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int BIT_CNT_W  = 6;
  localparam int DCNT_W     = 5;

  localparam logic [CHAR_W-1:0]    ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0]    ASCII_MINUS = 8'd45;
  localparam logic [BIT_CNT_W-1:0] LAST_BIT    = 6'd63;
  localparam logic [DCNT_W-1:0]    ALL_DIGITS  = 5'd20;
  localparam logic [DCNT_W-1:0]    ONE_DIGIT   = 5'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture value, clear digits
    logic conv;      // one shift-add-3 step
    logic shift;     // drop the top digit
    logic sel_sign;  // drive the minus character
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic conv_last; // final binary bit is being shifted in
    logic top_zero;  // leading digit is zero
    logic one_left;  // only one digit remains
    logic neg;       // input was negative
  } dp_status_t;

  // add 3 to a BCD digit of 5 or more ahead of the doubling shift
  function automatic logic [3:0] dabble_adjust(input logic [3:0] d);
    dabble_adjust = (d >= 4'd5) ? (d + 4'd3) : d;
  endfunction

endpackage

`default_nettype wire

>>> sv/signed_binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii
// Renders a signed 64-bit integer as decimal ASCII, most significant first.
// ----------------------------------------------------------------------------
//  channel  | signals                   | handshake
//  ---------+---------------------------+------------------------------------
//  input    | value[63:0]               | taken when start && !busy
//  result   | character[7:0], last      | one cycle per character on strobe
//
//  After acceptance an item keeps the block busy through the conversion
//  (the shift-add-3 converter takes one input bit per cycle), then while
//  leading zeros are dropped to find the first digit, then one cycle per
//  character, with a minus sign first for a negative value.
//  A new item is taken only once the block is idle after the last character.
//  Characters leave on consecutive cycles; the receiver cannot stall them.
//  busy is high from the cycle after acceptance through the last character.
//  Synchronous reset returns the sequencer to idle; the datapath registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_binary_to_decimal_ascii
  import sbda_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [VALUE_W-1:0] value,
  output logic                    busy,
  output logic                    strobe,
  output logic [CHAR_W-1:0]       character,
  output logic                    last
);

  dp_cmd_t    cmd;
  dp_status_t status;

  sbda_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (strobe)
  );

  sbda_dp u_dp (
    .clk       (clk),
    .value     (value),
    .cmd       (cmd),
    .status    (status),
    .character (character),
    .last      (last)
  );

`ifndef NO_ASSERTIONS
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy) else $error("character emitted while idle");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> (!strobe && !busy)) else $error("output after last character");

  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |=> strobe) else $error("gap inside a number");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !strobe)) else $error("item not taken up");

  a_char_code: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (character == ASCII_MINUS ||
                (character >= ASCII_ZERO && character <= (ASCII_ZERO + 8'd9))))
    else $error("character out of range");
`endif

endmodule

`default_nettype wire

>>> sv/sbda_ctrl.sv
// ----------------------------------------------------------------------------
// sbda_ctrl
// Sequencer: converts until the last input bit is shifted in, skips leading
// zeros, then emits the sign of a negative value and the digits one character per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sbda_ctrl
  import sbda_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd,
  output logic            busy,
  output logic            strobe
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_CONV;
      end
      ST_CONV: begin
        if (status.conv_last) state_next = ST_SKIP;
      end
      ST_SKIP: begin
        if (!(status.top_zero && !status.one_left)) begin
          state_next = status.neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.one_left) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd          = '0;
    busy         = 1'b1;
    strobe       = 1'b0;
    case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_CONV: begin
        cmd.conv = 1'b1;
      end
      ST_SKIP: begin
        cmd.shift = status.top_zero && !status.one_left;
      end
      ST_SIGN: begin
        cmd.sel_sign = 1'b1;
        strobe       = 1'b1;
      end
      ST_EMIT: begin
        cmd.shift = 1'b1;
        strobe    = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/sbda_dp.sv
// ----------------------------------------------------------------------------
// sbda_dp
// Datapath: magnitude register, 20-digit shift-add-3 BCD register, bit and
// digit counters, character formatting.
// ----------------------------------------------------------------------------
`default_nettype none

module sbda_dp
  import sbda_pkg::*;
(
  input  wire logic               clk,
  input  wire logic [VALUE_W-1:0] value,
  input  wire dp_cmd_t            cmd,
  output dp_status_t              status,
  output logic [CHAR_W-1:0]       character,
  output logic                    last
);

  logic [VALUE_W-1:0]   mag;
  logic [BCD_W-1:0]     bcd;
  logic [BCD_W-1:0]     bcd_adj;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [DCNT_W-1:0]    dcnt;
  logic                 neg;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = dabble_adjust(bcd[4*i +: 4]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg     <= value[VALUE_W-1];
      mag     <= value[VALUE_W-1] ? (~value + {{(VALUE_W-1){1'b0}}, 1'b1}) : value;
      bcd     <= '0;
      bit_cnt <= '0;
      dcnt    <= ALL_DIGITS;
    end else if (cmd.conv) begin
      bcd     <= {bcd_adj[BCD_W-2:0], mag[VALUE_W-1]};
      mag     <= {mag[VALUE_W-2:0], 1'b0};
      bit_cnt <= bit_cnt + 1'b1;
    end else if (cmd.shift) begin
      bcd  <= {bcd[BCD_W-5:0], 4'd0};
      dcnt <= dcnt - 1'b1;
    end
  end

  assign status.conv_last = (bit_cnt == LAST_BIT);
  assign status.top_zero  = (bcd[BCD_W-1 -: 4] == 4'd0);
  assign status.one_left  = (dcnt == ONE_DIGIT);
  assign status.neg       = neg;

  assign character = cmd.sel_sign ? ASCII_MINUS : (ASCII_ZERO + {4'd0, bcd[BCD_W-1 -: 4]});
  assign last      = !cmd.sel_sign && status.one_left;

endmodule

`default_nettype wire

>>> tb/signed_binary_to_decimal_ascii_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii_tb
// Sends signed 64-bit values and checks every decimal ASCII character that
// comes back against a software rendering of the same value. The sender
// works in random bursts with random gaps between them.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_binary_to_decimal_ascii_tb;
  import sbda_pkg::*;

  localparam logic [VALUE_W-1:0] RADIX    = 64'd10;
  localparam logic [VALUE_W-1:0] MOST_NEG = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [VALUE_W-1:0] MOST_POS = {1'b0, {(VALUE_W-1){1'b1}}};

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              fin;
  } text_char_t;

  logic               clk   = 1'b0;
  logic               rst   = 1'b1;
  logic               start = 1'b0;
  logic [VALUE_W-1:0] value = '0;
  logic               busy;
  logic               strobe;
  logic [CHAR_W-1:0]  character;
  logic               last;

  text_char_t expected_chars[$];
  int         error_count = 0;
  int         burst_left  = 0;

  signed_binary_to_decimal_ascii DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .value     (value),
    .busy      (busy),
    .strobe    (strobe),
    .character (character),
    .last      (last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Queue the decimal text of v: optional minus, then digits without leading zeros.
  task automatic predict_text(input logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] mag;
    logic [3:0]         digs[NUM_DIGITS];
    int                 nd;
    int                 i;
    mag = v[VALUE_W-1] ? (~v + 64'd1) : v;
    nd  = 0;
    do begin
      digs[nd] = 4'(mag % RADIX);
      mag      = mag / RADIX;
      nd++;
    end while (mag != 0 && nd < NUM_DIGITS);
    if (v[VALUE_W-1]) begin
      expected_chars.push_back(text_char_t'{ASCII_MINUS, 1'b0});
    end
    for (i = nd - 1; i >= 0; i--) begin
      expected_chars.push_back(text_char_t'{ASCII_ZERO + {4'd0, digs[i]}, i == 0});
    end
  endtask

  // Hold start until the item is taken, then end the burst with a gap if due.
  task automatic send_value(input logic [VALUE_W-1:0] v);
    int gap;
    start <= 1'b1;
    value <= v;
    do begin
      @(posedge clk);
    end while (busy);
    predict_text(v);
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      start <= 1'b0;
      value <= {$urandom, $urandom};
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end
  endtask

  // Mix of full-width noise, values around powers of ten and short magnitudes.
  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] mag;
    int                 pick;
    int                 n;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      mag = {$urandom, $urandom};
    end else if (pick < 4) begin
      mag = 64'd1;
      n   = $urandom_range(0, 18);
      repeat (n) mag = mag * RADIX;
      mag = mag + 64'($urandom_range(0, 2)) - 64'd1;
    end else begin
      mag = {$urandom, $urandom} >> $urandom_range(0, 63);
    end
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  task automatic test_directed_values();
    send_value(64'd0);
    send_value(64'd1);
    send_value(-64'd1);
    send_value(64'd9);
    send_value(-64'd9);
    send_value(64'd10);
    send_value(-64'd10);
    send_value(64'd99);
    send_value(64'd100);
    send_value(64'd12345);
    send_value(-64'd67890);
    send_value(64'd999999999999999999);
    send_value(64'd1000000000000000000);
    send_value(-64'd1000000000000000000);
    send_value(MOST_POS);
    send_value(MOST_NEG);
    send_value(MOST_NEG + 64'd1);
    send_value(64'h0000_0000_FFFF_FFFF);
    send_value(64'hAAAA_AAAA_AAAA_AAAA);
    send_value(64'h5555_5555_5555_5555);
  endtask

  task automatic test_back_to_back_values();
    int k;
    burst_left = 12;
    for (k = 0; k < 12; k++) begin
      send_value(random_value());
    end
  endtask

  task automatic test_random_values(input int count);
    int k;
    for (k = 0; k < count; k++) begin
      send_value(random_value());
    end
  endtask

  // Match each strobed character against the oldest expected one.
  always @(posedge clk) begin
    text_char_t want;
    if (!rst && strobe) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual %0d last %b",
                 $time, character, last);
        error_count++;
      end else begin
        want = expected_chars.pop_front();
        if (character !== want.ch) begin
          $display("%0t: character mismatch: expected %0d, actual %0d",
                   $time, want.ch, character);
          error_count++;
        end
        if (last !== want.fin) begin
          $display("%0t: last mismatch: expected %b, actual %b", $time, want.fin, last);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    burst_left = $urandom_range(1, 10);
    test_directed_values();
    test_back_to_back_values();
    test_random_values(140);
    start <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("timeout with %0d characters outstanding", expected_chars.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
